FILE: design/lbcd_pkg.sv
package lbcd_pkg;
  localparam int SLOTS_DEF = 16;
  localparam logic [4:0] SLOTS_IN_USE_RESET = 5'd16;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_ERASE = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [7:0]  hit_idx;
    logic        inv_found;
    logic [7:0]  inv_idx;
    logic [7:0]  old_idx;
    logic [31:0] old_stamp;
  } scan_t;

  // command broadcast to the cells
  typedef struct packed {
    logic        scan_en;
    logic        write_en;
    logic        stamp_en;
    logic        erase_en;
    logic [7:0]  sel;
    logic [31:0] blk;
    logic [31:0] stamp;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        range_ok;
    logic [8:0]  n;
  } cmd_t;
endpackage

FILE: design/lbcd_cell.sv
module lbcd_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  lbcd_pkg::cmd_t   cmd,
  input  lbcd_pkg::scan_t  scan_in,
  output lbcd_pkg::scan_t  scan_out
);
  logic        valid;
  logic [31:0] blk;
  logic [31:0] stamp;
  logic        active;
  logic        is_sel;

  assign active = 9'(IDX) < cmd.n;
  assign is_sel = cmd.sel == 8'(IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      blk   <= '0;
      stamp <= '0;
    end else begin
      if (cmd.write_en && is_sel) begin
        valid <= 1'b1;
        blk   <= cmd.blk;
        stamp <= cmd.stamp;
      end else if (cmd.stamp_en && is_sel) begin
        stamp <= cmd.stamp;
      end else if (cmd.erase_en && active && valid && cmd.range_ok &&
                   blk >= cmd.lo && blk < cmd.hi) begin
        valid <= 1'b0;
      end
    end
  end

  // registered hop: each cell adds its slot to the token
  always_ff @(posedge clk) begin
    scan_out <= scan_in;
    if (cmd.scan_en && active) begin
      if (!scan_in.found && valid && blk == cmd.blk) begin
        scan_out.found   <= 1'b1;
        scan_out.hit_idx <= 8'(IDX);
      end
      if (!scan_in.inv_found && !valid) begin
        scan_out.inv_found <= 1'b1;
        scan_out.inv_idx   <= 8'(IDX);
      end
      if (IDX == 0 || stamp < scan_in.old_stamp) begin
        scan_out.old_idx   <= 8'(IDX);
        scan_out.old_stamp <= stamp;
      end
    end
  end
endmodule

FILE: design/lru_block_cache_directory_core.sv
// Tag directory of a fully associative, write-through block cache with LRU
// replacement. One request (read, write or erase of a block address plus the
// backend outcome) gives one response with status, hit, slot index and the
// running hit and miss totals. Slots live in a chain of cells; a scan token
// walks the chain one cell per cycle collecting the hit slot, first invalid
// slot and oldest stamp. A request passes through the scan state, whose
// length is set by the length of the chain, then the apply and output states;
// one request is in flight at a time. A new request is accepted in the cycle
// its predecessor's response is taken. slots_in_use may be written only while
// idle; 0 acts as 1 and values above SLOTS act as SLOTS.
module lru_block_cache_directory_core #(
  parameter int SLOTS = lbcd_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] lba,
  input  logic [31:0] erase_count,
  input  logic        backend_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        hit,
  output logic [3:0]  slot_index,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total
);
  localparam int CW = $clog2(SLOTS + 2);

  lbcd_pkg::state_t state, state_next;
  logic [4:0]  slots_in_use;
  logic [1:0]  r_act;
  logic [31:0] r_lba, r_end;
  logic        r_ok;
  logic [31:0] use_clock, hit_counter, miss_counter;
  logic [CW-1:0] cnt;
  logic [8:0]  n;
  lbcd_pkg::cmd_t cmd;
  lbcd_pkg::scan_t chain [SLOTS+1];
  lbcd_pkg::scan_t res;

  // effective slot count
  always_comb begin
    n = 9'(slots_in_use);
    if (n == 9'd0) n = 9'd1;
    if (n > 9'(SLOTS)) n = 9'(SLOTS);
  end

  assign chain[0] = '0;
  assign res      = chain[SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lbcd_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .scan_in(chain[g]), .scan_out(chain[g+1])
    );
  end

  assign in_ready  = (state == lbcd_pkg::ST_IDLE) ||
                     (state == lbcd_pkg::ST_OUT && out_ready);
  assign out_valid = state == lbcd_pkg::ST_OUT;
  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;

  logic do_read, do_write, do_erase;
  logic [7:0] victim, pick;
  logic [31:0] clk_bump;
  assign do_read  = r_act == lbcd_pkg::ACT_READ;
  assign do_write = r_act == lbcd_pkg::ACT_WRITE && r_ok;
  assign do_erase = r_act == lbcd_pkg::ACT_ERASE && r_ok;
  assign victim   = res.inv_found ? res.inv_idx : res.old_idx;
  assign pick     = res.found ? res.hit_idx : victim;
  assign clk_bump = use_clock + 32'd1;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.blk      = r_lba;
    cmd.lo       = r_lba;
    cmd.hi       = r_end;
    cmd.range_ok = r_end >= r_lba;
    cmd.n        = n;
    cmd.sel      = pick;
    cmd.stamp    = clk_bump;
    case (state)
      lbcd_pkg::ST_IDLE: if (in_valid) state_next = lbcd_pkg::ST_SCAN;
      lbcd_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (cnt == CW'(SLOTS)) state_next = lbcd_pkg::ST_APPLY;
      end
      lbcd_pkg::ST_APPLY: begin
        cmd.write_en = do_write || (do_read && !res.found && r_ok);
        cmd.stamp_en = do_read && res.found;
        cmd.erase_en = do_erase;
        state_next = lbcd_pkg::ST_OUT;
      end
      lbcd_pkg::ST_OUT: if (out_ready) begin
        state_next = in_valid ? lbcd_pkg::ST_SCAN : lbcd_pkg::ST_IDLE;
      end
      default: state_next = lbcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lbcd_pkg::ST_IDLE;
      slots_in_use <= lbcd_pkg::SLOTS_IN_USE_RESET;
      use_clock    <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      cnt          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) slots_in_use <= cfg_data;
      if (in_valid && in_ready) cnt <= '0;
      else if (state == lbcd_pkg::ST_SCAN) cnt <= cnt + CW'(1);
      if (state == lbcd_pkg::ST_APPLY) begin
        if (do_read || do_write) use_clock <= clk_bump;
        if (do_read && res.found)  hit_counter  <= hit_counter + 32'd1;
        if (do_read && !res.found) miss_counter <= miss_counter + 32'd1;
      end
    end
  end

  // request capture and response fields
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_act <= action;
      r_lba <= lba;
      r_end <= lba + erase_count;
      r_ok  <= backend_ok;
    end
    if (state == lbcd_pkg::ST_APPLY) begin
      status     <= 1'b0;
      hit        <= 1'b0;
      slot_index <= '0;
      if (do_read) begin
        hit        <= res.found;
        slot_index <= pick[3:0];
        status     <= !res.found && !r_ok;
      end else if (r_act == lbcd_pkg::ACT_WRITE || r_act == lbcd_pkg::ACT_ERASE) begin
        status <= !r_ok;
        if (do_write) begin
          hit        <= res.found;
          slot_index <= pick[3:0];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_index))
    else $error("response dropped while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    state == lbcd_pkg::ST_APPLY && r_act == lbcd_pkg::ACT_READ
    |=> hit_counter + miss_counter == $past(hit_counter + miss_counter) + 32'd1)
    else $error("read not counted once");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == lbcd_pkg::ST_APPLY |-> $past(state) == lbcd_pkg::ST_SCAN)
    else $error("apply without scan");
`endif
endmodule
